/* rtl/dsmcc_section_filter_assert.svh */
// Assertion macros for the DSM-CC section filter.
// Included by the modules that carry concurrent assertions.
`ifndef DSMCC_SECTION_FILTER_ASSERT_SVH
`define DSMCC_SECTION_FILTER_ASSERT_SVH
// Property that must hold on every clock edge out of reset.
`define DSF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Property that must hold also during reset.
`define DSF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`endif

/* rtl/dsf_pkg.sv */
// Package for the DSM-CC section filter: constants, types and CRC helper.
// No dependencies.
package dsf_pkg;
  localparam int TapSlots = 16;
  localparam int TapIdxW = (TapSlots > 1) ? $clog2(TapSlots) : 1;
  localparam int MaxSectionBytes = 4096;
  localparam int CountW = 13;
  localparam int HdrBytes = 26;
  localparam logic [31:0] CrcPoly = 32'h04c11db7;
  localparam logic [7:0] TidIndication = 8'h3b;
  localparam logic [7:0] TidData = 8'h3c;
  localparam logic [7:0] TidDescr = 8'h3d;
  localparam logic [15:0] MsgDsi = 16'h1006;
  localparam logic [15:0] MsgDii = 16'h1002;
  localparam logic [15:0] MsgDdb = 16'h1003;
  localparam logic [7:0] ProtoDsmcc = 8'h11;
  localparam logic [7:0] HdrTypeUn = 8'h03;
  localparam logic [15:0] BidReset = 16'h0106;
  localparam logic [15:0] MaxMsgReset = 16'd4076;
  localparam int QDepth = 2;

  typedef enum logic [0:0] { CfgBid = 1'b0, CfgMaxMsg = 1'b1 } cfg_idx_e;

  typedef enum logic [3:0] {
    StOk = 4'd0, StUnknown = 4'd1, StLength = 4'd2, StCrc = 4'd3, StFlags = 4'd4,
    StProtocol = 4'd5, StHdrType = 4'd6, StMsgId = 4'd7, StMsgLen = 4'd8,
    StForeign = 4'd9, StCarousel = 4'd10, StTableId = 4'd11, StShort = 4'd12
  } status_e;

  typedef enum logic [1:0] {
    KindDsi = 2'd0, KindDii = 2'd1, KindDdb = 2'd2, KindDescr = 2'd3
  } kind_e;

  // Finished section handed from the front to the back
  typedef struct packed {
    logic [CountW-1:0] len;
    logic              crc_bad;
    logic [HdrBytes*8-1:0] hdr;
    logic [15:0]       tag;
    logic [31:0]       car;
    logic [15:0]       bid;
  } sect_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [1:0]  kind;
    logic [7:0]  tid;
    logic [31:0] dl;
    logic [15:0] modn;
    logic [7:0]  modr;
    logic [15:0] blk;
    logic [15:0] blen;
    logic        became;
  } result_t;

  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction
endpackage

/* rtl/dsf_front.sv */
// Front end: byte count, CRC-32/MPEG-2 and header capture per section.
// Depends on dsf_pkg.
module dsf_front import dsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_i,
  input  logic        first_i,
  input  logic        last_i,
  input  logic [15:0] tag_i,
  input  logic [31:0] car_i,
  input  logic [15:0] bid_i,
  output logic        sect_valid_o,
  input  logic        sect_ready_i,
  output sect_t       sect_o
);
  logic [CountW-1:0] cnt_q, cnt_d, cnt0;
  logic [31:0] crc_q, crc_d, crc0, end_q, end_d, end0;
  logic [7:0] hdr_q [HdrBytes];
  logic [HdrBytes*8-1:0] hdr_flat;
  logic [12:0] slen;
  logic [7:0] h1, h2;
  logic take, grow;

  // Queue slots between front and back
  sect_t q_mem [QDepth];
  logic [0:0] wr_q, rd_q;
  logic [1:0] fill_q;

  assign in_ready_o = (fill_q != 2'(QDepth));
  assign take = in_valid_i && in_ready_o;

  always_comb begin
    cnt0 = first_i ? '0 : cnt_q;
    crc0 = first_i ? 32'hffffffff : crc_q;
    end0 = first_i ? 32'h0 : end_q;
    grow = (cnt0 < CountW'(MaxSectionBytes));
    // bytes 1 and 2 may arrive in this very transaction
    h1 = (cnt0 == CountW'(1)) ? byte_i : hdr_q[1];
    h2 = (cnt0 == CountW'(2)) ? byte_i : hdr_q[2];
    slen = {1'b0, h1[3:0], h2} + 13'd3;
    cnt_d = cnt0;
    crc_d = crc0;
    end_d = end0;
    if (grow) begin
      crc_d = crc_byte(crc0, byte_i);
      cnt_d = cnt0 + 1'b1;
      if (cnt_d >= CountW'(3) && cnt_d == slen) end_d = crc_d;
    end
    for (int i = 0; i < HdrBytes; i++) begin
      hdr_flat[(HdrBytes-1-i)*8 +: 8] = (grow && cnt0 == CountW'(i)) ? byte_i : hdr_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      crc_q <= 32'hffffffff;
      end_q <= '0;
      for (int i = 0; i < HdrBytes; i++) hdr_q[i] <= '0;
    end else if (take) begin
      for (int i = 0; i < HdrBytes; i++) hdr_q[i] <= hdr_flat[(HdrBytes-1-i)*8 +: 8];
      if (last_i) begin
        cnt_q <= '0;
        crc_q <= 32'hffffffff;
        end_q <= end_d;
      end else begin
        cnt_q <= cnt_d;
        crc_q <= crc_d;
        end_q <= end_d;
      end
    end
  end

  // Push a finished section, pop when the back takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      fill_q <= '0;
    end else begin
      if (take && last_i) wr_q <= wr_q + 1'b1;
      if (sect_valid_o && sect_ready_i) rd_q <= rd_q + 1'b1;
      fill_q <= fill_q + 2'(take && last_i) - 2'(sect_valid_o && sect_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && last_i) begin
      q_mem[wr_q] <= '{len: cnt_d, crc_bad: (end_d != 32'h0), hdr: hdr_flat,
                       tag: tag_i, car: car_i, bid: bid_i};
    end
  end

  assign sect_valid_o = (fill_q != 2'd0);
  assign sect_o = q_mem[rd_q];
endmodule

/* rtl/dsf_back.sv */
// Back end: tap table lookup, section checks and result register.
// Depends on dsf_pkg and the assertion header.
`include "dsmcc_section_filter_assert.svh"
module dsf_back import dsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  cfg_idx_e    cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        sect_valid_i,
  output logic        sect_ready_o,
  input  sect_t       sect_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output result_t     res_o
);
  logic [15:0] bid_q, maxm_q, start_q;
  logic [TapSlots-1:0] tv_q;
  logic [15:0] tt_q [TapSlots];
  logic [31:0] tc_q [TapSlots];
  logic found_tag, have_free, add, found, known_dl, take;
  logic [TapIdxW-1:0] free_idx;
  logic [7:0] h [HdrBytes];
  logic [CountW-1:0] len;
  logic [12:0] slen;
  logic [15:0] mid, mlen;
  logic [4:0] need;
  result_t r;
  logic rv_q;

  assign sect_ready_o = !rv_q || res_ready_i;
  assign take = sect_valid_i && sect_ready_o;

  always_comb begin
    for (int i = 0; i < HdrBytes; i++) h[i] = sect_i.hdr[(HdrBytes-1-i)*8 +: 8];
    len = sect_i.len;
    found_tag = 1'b0;
    have_free = 1'b0;
    free_idx = '0;
    for (int i = TapSlots-1; i >= 0; i--) begin
      if (tv_q[i] && tt_q[i] == sect_i.tag) found_tag = 1'b1;
      if (!tv_q[i]) begin
        have_free = 1'b1;
        free_idx = TapIdxW'(i);
      end
    end
    add = !found_tag && sect_i.bid == bid_q && have_free;
    found = found_tag || add;
    slen = {1'b0, h[1][3:0], h[2]} + 13'd3;
    mid = (len >= CountW'(12)) ? {h[10], h[11]} : 16'h0;
    mlen = (len >= CountW'(20)) ? {h[18], h[19]} : 16'h0;
    r = '0;
    r.became = add;
    r.tid = (len >= CountW'(1)) ? h[0] : 8'h0;
    need = (r.tid == TidData) ? 5'd26 : (mid == MsgDii) ? 5'd24 : 5'd20;
    if (!found) r.status = StUnknown;
    else if (len < CountW'(3)) r.status = StShort;
    else if ({1'b0, slen} > {1'b0, len}) r.status = StLength;
    else if (sect_i.crc_bad) r.status = StCrc;
    else if (r.tid != TidIndication && r.tid != TidData && r.tid != TidDescr)
      r.status = StTableId;
    else if (r.tid == TidDescr) begin
      r.kind = KindDescr;
      if (len < CountW'(7)) r.status = StShort;
    end else begin
      r.kind = (r.tid == TidData) ? KindDdb :
               (mid == MsgDii) ? KindDii : KindDsi;
      if (len < CountW'(need)) r.status = StShort;
      else if (!h[1][7] || h[1][6]) r.status = StFlags;
      else if (h[8] != ProtoDsmcc) r.status = StProtocol;
      else if (h[9] != HdrTypeUn) r.status = StHdrType;
      else if (r.tid == TidData) begin
        if (mid != MsgDdb) r.status = StMsgId;
        else begin
          r.dl = {h[12], h[13], h[14], h[15]};
          r.modn = {h[20], h[21]};
          r.modr = h[22];
          r.blk = {h[24], h[25]};
          r.blen = (mlen > 16'd6) ? mlen - 16'd6 : 16'h0;
        end
      end else if (mid != MsgDsi && mid != MsgDii) r.status = StMsgId;
      else if (mlen > maxm_q) r.status = StMsgLen;
      else if (mid == MsgDsi) begin
        if (sect_i.tag != (add ? sect_i.tag : start_q)) r.status = StForeign;
      end else r.dl = {h[20], h[21], h[22], h[23]};
    end
    // carousel search sees the table before this section's insertion
    // except for the new entry itself
    known_dl = 1'b0;
    for (int i = 0; i < TapSlots; i++) begin
      if (tv_q[i] && tc_q[i] == r.dl) known_dl = 1'b1;
    end
    if (r.status == StOk && (r.kind == KindDdb || r.kind == KindDii) &&
        !(known_dl || (add && sect_i.car == r.dl))) r.status = StCarousel;
  end

  // Configuration and tap table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bid_q <= BidReset;
      maxm_q <= MaxMsgReset;
      start_q <= '0;
      tv_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgBid:    bid_q <= cfg_data_i;
          CfgMaxMsg: maxm_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (take && add) begin
        tv_q[free_idx] <= 1'b1;
        start_q <= sect_i.tag;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && add) begin
      tt_q[free_idx] <= sect_i.tag;
      tc_q[free_idx] <= sect_i.car;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q <= 1'b0;
    else if (sect_ready_o) rv_q <= sect_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (take) res_o <= r;
  end

  assign res_valid_o = rv_q;

  `DSF_ASSERT(a_hold, rv_q && !res_ready_i |=> rv_q && $stable(res_o), "result dropped")
  `DSF_ASSERT(a_became, take && add |=> tv_q != 0, "tap not added")
  `DSF_ASSERT(a_st, rv_q |-> res_o.status <= StShort, "bad status")
endmodule

/* rtl/dsmcc_section_filter.sv */
// DSM-CC section filter: one byte per cycle while the section queue has room, one result per section.
// Throughput: one byte every cycle, with back-to-back sections, while the result side keeps accepting.
// The two-entry section queue and output register decouple the two sides.
// Reset: asynchronous, clears the tap table and counters and presets the CRC.
// Top level: instantiates dsf_front and dsf_back from dsf_pkg.
module dsmcc_section_filter import dsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // section_byte, stream_tag, carousel_ident, broadcast_id
  input  logic        s_axis_tlast,  // last_byte
  input  logic        s_axis_tuser,  // first_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status, message_kind, table_ident, download_ident, module_number,
  // module_revision, block_index, block_length, became_start_stream
  output logic [103:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  logic sv, sr;
  sect_t s;
  result_t r;

  assign cfg_ready_o = 1'b1;

  dsf_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .byte_i(s_axis_tdata[7:0]), .first_i(s_axis_tuser), .last_i(s_axis_tlast),
    .tag_i(s_axis_tdata[23:8]), .car_i(s_axis_tdata[55:24]), .bid_i(s_axis_tdata[71:56]),
    .sect_valid_o(sv), .sect_ready_i(sr), .sect_o(s)
  );

  dsf_back u_back (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_valid_i), .cfg_idx_i(cfg_idx_e'(cfg_index_i)), .cfg_data_i,
    .sect_valid_i(sv), .sect_ready_o(sr), .sect_i(s),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(r)
  );

  assign m_axis_tdata = {1'b0, r.became, r.blen, r.blk, r.modr, r.modn, r.dl,
                         r.tid, r.kind, r.status};
endmodule

/* tb/sv/dsmcc_section_filter_tb.sv */
// Self-checking testbench for the DSM-CC section filter: streams sections byte by byte,
// predicts each section result and checks it field by field. Depends on dsf_pkg and the RTL.
module dsmcc_section_filter_tb import dsf_pkg::*; ();

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [3:0]  status;
    logic [1:0]  kind;
    logic [7:0]  tid;
    logic [31:0] dl;
    logic [15:0] modn;
    logic [7:0]  modr;
    logic [15:0] blk;
    logic [15:0] blen;
    logic        became;
  } section_result_t;

  // Predicts section results from accepted bytes and checks delivered results
  class section_scoreboard;
    logic [15:0] acc_bid = BidReset;
    logic [15:0] max_len = MaxMsgReset;
    bit          tap_v[TapSlots];
    logic [15:0] tap_tag[TapSlots];
    logic [31:0] tap_car[TapSlots];
    logic [15:0] start_tag = '0;
    int          count = 0;
    logic [31:0] crc = '1;
    logic [31:0] crc_end = '0;
    logic [7:0]  hdr[HdrBytes];
    section_result_t expected_q[$];
    int          mismatches = 0;
    int          results = 0;

    function int pending();
      return expected_q.size();
    endfunction

    function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      c = c ^ {b, 24'h0};
      for (int i = 0; i < 8; i++) c = c[31] ? ((c << 1) ^ 32'h04c11db7) : (c << 1);
      return c;
    endfunction

    function bit carousel_known(logic [31:0] id);
      foreach (tap_v[i]) if (tap_v[i] && tap_car[i] == id) return 1;
      return 0;
    endfunction

    function void write_cfg(cfg_idx_e idx, logic [15:0] d);
      if (idx == CfgBid) acc_bid = d;
      else max_len = d;
    endfunction

    // Advance the section state by one accepted byte; queue a result on the last one
    function void note_byte(logic [7:0] b, bit first, bit last, logic [15:0] tag,
                            logic [31:0] car, logic [15:0] bid);
      section_result_t r;
      int len, slen, need, free_slot;
      bit found;
      logic [15:0] mid, mlen;
      if (first) begin
        count = 0;
        crc = '1;
        crc_end = '0;
      end
      if (count < MaxSectionBytes) begin
        if (count < HdrBytes) hdr[count] = b;
        crc = crc_step(crc, b);
        count++;
        if (count >= 3 && count == {hdr[1][3:0], 8'h0} + hdr[2] + 3) crc_end = crc;
      end
      if (!last) return;
      len = count;
      count = 0;
      crc = '1;
      r = '{default: '0};
      found = 0;
      free_slot = -1;
      foreach (tap_v[i]) begin
        if (tap_v[i] && tap_tag[i] == tag) found = 1;
        if (!tap_v[i] && free_slot < 0) free_slot = i;
      end
      if (!found && bid == acc_bid && free_slot >= 0) begin
        tap_v[free_slot] = 1;
        tap_tag[free_slot] = tag;
        tap_car[free_slot] = car;
        start_tag = tag;
        r.became = 1;
        found = 1;
      end
      if (len >= 1) r.tid = hdr[0];
      if (!found) r.status = StUnknown;
      else if (len < 3) r.status = StShort;
      else begin
        slen = {hdr[1][3:0], 8'h0} + hdr[2] + 3;
        if (slen > len) r.status = StLength;
        else if (crc_end != 0) r.status = StCrc;
        else if (!(r.tid inside {TidIndication, TidData, TidDescr})) r.status = StTableId;
        else if (r.tid == TidDescr) begin
          r.kind = KindDescr;
          if (len < 7) r.status = StShort;
        end else begin
          r.kind = (r.tid == TidData) ? KindDdb : KindDsi;
          mid = (len >= 12) ? {hdr[10], hdr[11]} : 16'h0;
          need = (r.tid == TidData) ? 26 : (mid == MsgDii) ? 24 : 20;
          if (r.tid == TidIndication && mid == MsgDii) r.kind = KindDii;
          mlen = (len >= 20) ? {hdr[18], hdr[19]} : 16'h0;
          if (len < need) r.status = StShort;
          else if (!hdr[1][7] || hdr[1][6]) r.status = StFlags;
          else if (hdr[8] != ProtoDsmcc) r.status = StProtocol;
          else if (hdr[9] != HdrTypeUn) r.status = StHdrType;
          else if (r.tid == TidData) begin
            if (mid != MsgDdb) r.status = StMsgId;
            else begin
              r.dl = {hdr[12], hdr[13], hdr[14], hdr[15]};
              r.modn = {hdr[20], hdr[21]};
              r.modr = hdr[22];
              r.blk = {hdr[24], hdr[25]};
              r.blen = (mlen > 16'd6) ? 16'(mlen - 16'd6) : 16'h0;
              if (!carousel_known(r.dl)) r.status = StCarousel;
            end
          end else if (mid != MsgDsi && mid != MsgDii) r.status = StMsgId;
          else if (mlen > max_len) r.status = StMsgLen;
          else if (mid == MsgDsi) begin
            if (tag != start_tag) r.status = StForeign;
          end else begin
            r.dl = {hdr[20], hdr[21], hdr[22], hdr[23]};
            if (!carousel_known(r.dl)) r.status = StCarousel;
          end
        end
      end
      expected_q = {expected_q, r};
    endfunction

    function void compare_field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on result %0d, %s: expected %h, got %h", results, name, e, a);
      end
    endfunction

    // Compare one delivered result with the oldest expectation
    function void check(logic [103:0] d);
      section_result_t e;
      results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d: %h", results, d);
        return;
      end
      e = expected_q.pop_front();
      compare_field("status", e.status, d[3:0]);
      compare_field("message_kind", e.kind, d[5:4]);
      compare_field("table_ident", e.tid, d[13:6]);
      compare_field("download_ident", e.dl, d[45:14]);
      compare_field("module_number", e.modn, d[61:46]);
      compare_field("module_revision", e.modr, d[69:62]);
      compare_field("block_index", e.blk, d[85:70]);
      compare_field("block_length", e.blen, d[101:86]);
      compare_field("became_start_stream", e.became, d[102]);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;  // section_byte, stream_tag, carousel_ident, broadcast_id
  logic s_axis_tlast = 1'b0;       // last_byte
  logic s_axis_tuser = 1'b0;       // first_byte
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // status, message_kind, table_ident, download_ident, module_number,
  // module_revision, block_index, block_length, became_start_stream
  logic [103:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  section_scoreboard sb = new();
  bit quiet = 0;
  int bytes_sent = 0;
  int sections_sent = 0;
  int sink_stall = 0;
  logic [15:0] tag_pool[24];
  logic [31:0] car_pool[8];

  dsmcc_section_filter u_dut (.*);

  initial forever #6 clk_i = ~clk_i;

  // Hold off the result side in random bursts
  always @(posedge clk_i) begin
    if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(9) == 0) begin
      sink_stall <= $urandom_range(18);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Check each result transaction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
  end

  task automatic send_byte(logic [7:0] b, bit first, bit last, logic [15:0] tag,
                           logic [31:0] car, logic [15:0] bid);
    if (!quiet && $urandom_range(9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(19, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {bid, car, tag, b};
    s_axis_tlast <= last;
    s_axis_tuser <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(b, first, last, tag, car, bid);
    bytes_sent++;
  endtask

  task automatic send_section(byte_q_t q, bit mark_first, logic [15:0] tag,
                              logic [31:0] car, logic [15:0] bid);
    foreach (q[i]) send_byte(q[i], mark_first && i == 0, i == q.size() - 1, tag, car, bid);
    sections_sent++;
  endtask

  // Drop the source to idle and wait for every outstanding result
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [15:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_cfg(idx, d);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Build a well-formed section of the given kind, then apply one fault
  // (0 none, 1 corrupt byte, 2 flags, 3 protocol, 4 header type,
  //  5 message id, 6 table id, 7 truncated)
  function automatic byte_q_t build_section(kind_e k, int extra, int fault);
    byte_q_t q;
    int body, slen, pos;
    logic [31:0] c;
    body = (k == KindDsi) ? 20 : (k == KindDii) ? 24 : (k == KindDdb) ? 26 : 3;
    body += extra;
    slen = body + 1;
    for (int i = 0; i < body; i++) q = {q, 8'($urandom_range(255))};
    q[0] = (k == KindDdb) ? TidData : (k == KindDescr) ? TidDescr : TidIndication;
    q[1] = {2'b10, 2'($urandom_range(3)), 4'(slen >> 8)};
    q[2] = slen[7:0];
    if (k != KindDescr) begin
      q[8] = ProtoDsmcc;
      q[9] = HdrTypeUn;
      {q[10], q[11]} = (k == KindDsi) ? MsgDsi : (k == KindDii) ? MsgDii : MsgDdb;
      {q[18], q[19]} = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(300));
      if (k == KindDdb) {q[12], q[13], q[14], q[15]} = car_pool[$urandom_range(7)];
      if (k == KindDii) {q[20], q[21], q[22], q[23]} =
        ($urandom_range(4) == 0) ? $urandom : car_pool[$urandom_range(7)];
    end
    // Header faults only where the header bytes exist
    case (fault)
      2: q[1][7:6] = 2'($urandom_range(2));
      3: if (q.size() > 11) q[8] = 8'($urandom_range(255));
      4: if (q.size() > 11) q[9] = 8'($urandom_range(255));
      5: if (q.size() > 11) {q[10], q[11]} = 16'($urandom);
      6: q[0] = 8'($urandom_range(255));
      default: ;
    endcase
    c = '1;
    foreach (q[i]) c = sb.crc_step(c, q[i]);
    for (int i = 3; i >= 0; i--) q = {q, c[i*8 +: 8]};
    if (fault == 1) begin
      pos = $urandom_range(q.size() - 1);
      q[pos] = q[pos] ^ 8'($urandom_range(255, 1));
    end
    if (fault == 7) repeat ($urandom_range(3, 1)) void'(q.pop_back());
    return q;
  endfunction

  // One random section or a burst of noise on a random stream
  task automatic random_section();
    byte_q_t q;
    logic [15:0] tag, bid;
    logic [31:0] car;
    tag = ($urandom_range(9) == 0) ? 16'($urandom) : tag_pool[$urandom_range(23)];
    car = ($urandom_range(3) == 0) ? $urandom : car_pool[$urandom_range(7)];
    bid = ($urandom_range(5) == 0) ? 16'($urandom) : sb.acc_bid;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(6, 1))
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), $urandom_range(3) == 0,
                  tag, car, bid);
    end else begin
      q = build_section(kind_e'($urandom_range(3)), $urandom_range(12),
                        ($urandom_range(3) == 0) ? $urandom_range(7, 1) : 0);
      send_section(q, $urandom_range(9) != 0, tag, car, bid);
    end
  endtask

  initial begin
    foreach (tag_pool[i]) tag_pool[i] = 16'($urandom);
    foreach (car_pool[i]) car_pool[i] = $urandom;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unknown stream, start stream, each kind and each fault
    send_section(build_section(KindDsi, 0, 0), 1, tag_pool[0], car_pool[0], 16'h0);
    send_section(build_section(KindDsi, 0, 0), 1, tag_pool[0], car_pool[0], sb.acc_bid);
    send_section(build_section(KindDii, 2, 0), 1, tag_pool[1], car_pool[1], sb.acc_bid);
    send_section(build_section(KindDdb, 0, 0), 1, tag_pool[0], car_pool[0], sb.acc_bid);
    send_section(build_section(KindDescr, 0, 0), 1, tag_pool[0], car_pool[0], 16'h0);
    for (int f = 1; f <= 7; f++)
      send_section(build_section(KindDdb, 1, f), 1, tag_pool[0], car_pool[0], 16'h0);
    // Sections of one and two bytes, and a first mark in mid-section
    send_section('{8'hff}, 1, tag_pool[0], 32'hffff_ffff, 16'hffff);
    send_section('{8'h00, 8'h00}, 1, tag_pool[0], car_pool[0], 16'h0);
    send_byte(8'h3c, 1, 0, tag_pool[0], car_pool[0], 16'h0);
    send_section(build_section(KindDsi, 0, 0), 1, tag_pool[0], car_pool[0], 16'h0);

    // Configuration extremes
    wait_idle();
    cfg_write(CfgBid, 16'hffff);
    cfg_write(CfgMaxMsg, 16'h0);
    repeat (3) random_section();
    wait_idle();
    cfg_write(CfgBid, 16'h0);
    cfg_write(CfgMaxMsg, 16'hffff);
    repeat (3) random_section();
    wait_idle();
    cfg_write(CfgBid, BidReset);
    cfg_write(CfgMaxMsg, 16'($urandom_range(400)));

    // Random sections until enough bytes have gone through
    while (bytes_sent < 640) begin
      if (sections_sent == 25) begin
        wait_idle();
        cfg_write(CfgBid, 16'($urandom));
        cfg_write(CfgMaxMsg, 16'($urandom_range(300)));
      end
      quiet = bytes_sent >= 560;
      random_section();
    end
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("sent %0d bytes in %0d sections, checked %0d results", bytes_sent,
             sections_sent, sb.results);
    $display("covered every message kind, header faults, short and unmarked sections");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("dsmcc_section_filter regression: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("dsmcc_section_filter regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(12 * 600000);
    $display("timeout");
    $display("dsmcc_section_filter regression: fail");
    $finish;
  end
endmodule

/* dsmcc_section_filter.f */
+incdir+rtl
rtl/dsf_pkg.sv
rtl/dsf_front.sv
rtl/dsf_back.sv
rtl/dsmcc_section_filter.sv
tb/sv/dsmcc_section_filter_tb.sv
